@@ hdl/mte_pkg.sv @@
// Shared types and constants of the MIDI track event encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mte_pkg;

   localparam int MTE_MAX_BYTES   = 14;
   localparam int MTE_VLQ_BYTES   = 4;
   localparam int MTE_BODY_BYTES  = 10;
   localparam int MTE_QUEUE_DEPTH = 2;
   localparam int MTE_REQ_DATA_W  = 160;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] count_type;

   typedef enum logic [2:0] {
      OP_NOTE_ON     = 3'd0,
      OP_TEMPO       = 3'd1,
      OP_TIME_SIG    = 3'd2,
      OP_SYSEX       = 3'd3,
      OP_START_TRACK = 3'd4,
      OP_END_TRACK   = 3'd5
   } op_type;

   localparam byte_type STATUS_NOTE_ON = 8'h90;
   localparam byte_type META_EVENT     = 8'hFF;
   localparam byte_type META_TEMPO     = 8'h51;
   localparam byte_type META_TEMPO_LEN = 8'h03;
   localparam byte_type META_TIME_SIG  = 8'h58;
   localparam byte_type META_TSIG_LEN  = 8'h04;
   localparam byte_type META_END_TRACK = 8'h2F;
   localparam byte_type SYSEX_START    = 8'hF0;
   localparam byte_type SYSEX_LEN      = 8'h08;
   localparam byte_type SYSEX_ID_P     = 8'h50;
   localparam byte_type SYSEX_ID_S     = 8'h53;
   localparam byte_type SYSEX_END      = 8'hF7;
   localparam byte_type CHUNK_M        = 8'h4D;
   localparam byte_type CHUNK_T        = 8'h54;
   localparam byte_type CHUNK_R        = 8'h72;
   localparam byte_type CHUNK_K        = 8'h6B;
   localparam byte_type VLQ_MORE       = 8'h80;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] position;
      logic [3:0]  channel;
      logic [6:0]  note_key;
      logic [6:0]  velocity;
      logic [24:0] tempo_micros;
      logic [31:0] timesig_bytes;
      logic [7:0]  sysex_difficulty;
      logic [7:0]  sysex_kind;
      logic        sysex_on;
   } request_type;

   typedef struct packed {
      byte_type [MTE_MAX_BYTES-1:0] bytes;
      count_type                    count;
      logic                         error;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hdl/midi_track_event_encoder.sv @@
// Top level of the MIDI track event encoder: front end, event queue, back end.
// Depends on mte_pkg, mte_front, mte_queue and mte_back.
// The bytes of an accepted event pass through the event queue and then the
// registered output stage; output is one byte per cycle while rsp_tready is
// high, an event has 1 to 14 bytes, and the input stalls while the event queue is full.
// Reset clears the track state, the queue and the output stage at once.
module midi_track_event_encoder #(
   parameter int QUEUE_DEPTH = mte_pkg::MTE_QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // position, channel, note_key, velocity, tempo_micros, timesig_bytes,
   // sysex_difficulty, sysex_kind, sysex_on, zero padding
   input  logic [mte_pkg::MTE_REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [2:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_byte
   output logic [7:0]                         rsp_tdata,
   output logic                               rsp_tlast,
   // error
   output logic                               rsp_tuser
);
   import mte_pkg::*;

   request_type      req;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type status;
   logic             push;
   logic             pop;

   assign req.operation        = req_tuser;
   assign req.position         = req_tdata[63:0];
   assign req.channel          = req_tdata[67:64];
   assign req.note_key         = req_tdata[74:68];
   assign req.velocity         = req_tdata[81:75];
   assign req.tempo_micros     = req_tdata[106:82];
   assign req.timesig_bytes    = req_tdata[138:107];
   assign req.sysex_difficulty = req_tdata[146:139];
   assign req.sysex_kind       = req_tdata[154:147];
   assign req.sysex_on         = req_tdata[155];

   mte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .status    (status),
      .push      (push),
      .entry     (push_entry)
   );

   mte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   mte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_byte  (rsp_tdata),
      .rsp_last  (rsp_tlast),
      .rsp_error (rsp_tuser)
   );

endmodule

@@ hdl/mte_front.sv @@
// Front end of the MIDI track event encoder: accepts events, computes the
// delta and running status, and builds the byte list of one event.
// Depends on mte_pkg.
module mte_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mte_pkg::request_type   req,
   input  mte_pkg::queue_status_type status,
   output logic                   push,
   output mte_pkg::entry_type     entry
);
   import mte_pkg::*;

   logic [31:0] last_position_ff, last_position_in;
   logic        last_note_on_ff, last_note_on_in;
   logic [3:0]  last_channel_ff, last_channel_in;

   logic [31:0] delta;
   logic        with_delta;
   logic        op_known;
   logic        fault;
   logic [2:0]  vlq_n;
   logic [2:0]  delta_n;
   logic [6:0]  grp [MTE_VLQ_BYTES];
   byte_type    vlq [MTE_VLQ_BYTES];
   byte_type    body [MTE_BODY_BYTES];
   count_type   body_n;
   logic [2:0]  gi_full;
   count_type   bi;
   logic        accept;

   assign req_ready = !status.full;
   assign accept    = req_valid && req_ready;
   assign delta     = req.position[31:0] - last_position_ff;

   always_comb begin
      op_known   = (req.operation <= OP_END_TRACK);
      with_delta = (req.operation <= OP_SYSEX);
      fault      = with_delta && ((delta[31:28] != 4'd0) ||
                   ((req.operation == OP_TEMPO) && req.tempo_micros[24]));
      priority if (delta[27:21] != 7'd0) begin
         vlq_n = 3'd4;
      end else if (delta[20:14] != 7'd0) begin
         vlq_n = 3'd3;
      end else if (delta[13:7] != 7'd0) begin
         vlq_n = 3'd2;
      end else begin
         vlq_n = 3'd1;
      end
      delta_n = with_delta ? vlq_n : 3'd0;
      gi_full = 3'd0;
      for (int j = 0; j < MTE_VLQ_BYTES; j++) begin
         grp[j] = delta[7*j +: 7];
      end
      for (int k = 0; k < MTE_VLQ_BYTES; k++) begin
         gi_full = vlq_n - 3'd1 - 3'(k);
         vlq[k]  = {(gi_full != 3'd0), grp[gi_full[1:0]]};
      end

      for (int b = 0; b < MTE_BODY_BYTES; b++) begin
         body[b] = 8'h00;
      end
      body_n          = 4'd0;
      last_position_in = last_position_ff;
      last_note_on_in  = last_note_on_ff;
      last_channel_in  = last_channel_ff;
      unique case (req.operation)
         OP_NOTE_ON: begin
            if (!last_note_on_ff || (last_channel_ff != req.channel)) begin
               body[0] = STATUS_NOTE_ON | {4'd0, req.channel};
               body[1] = {1'b0, req.note_key};
               body[2] = {1'b0, req.velocity};
               body_n  = 4'd3;
            end else begin
               body[0] = {1'b0, req.note_key};
               body[1] = {1'b0, req.velocity};
               body_n  = 4'd2;
            end
            last_note_on_in  = 1'b1;
            last_channel_in  = req.channel;
            last_position_in = req.position[31:0];
         end
         OP_TEMPO: begin
            body[0] = META_EVENT;
            body[1] = META_TEMPO;
            body[2] = META_TEMPO_LEN;
            body[3] = req.tempo_micros[23:16];
            body[4] = req.tempo_micros[15:8];
            body[5] = req.tempo_micros[7:0];
            body_n  = 4'd6;
            last_note_on_in  = 1'b0;
            last_position_in = req.position[31:0];
         end
         OP_TIME_SIG: begin
            body[0] = META_EVENT;
            body[1] = META_TIME_SIG;
            body[2] = META_TSIG_LEN;
            body[3] = req.timesig_bytes[31:24];
            body[4] = req.timesig_bytes[23:16];
            body[5] = req.timesig_bytes[15:8];
            body[6] = req.timesig_bytes[7:0];
            body_n  = 4'd7;
            last_note_on_in  = 1'b0;
            last_position_in = req.position[31:0];
         end
         OP_SYSEX: begin
            body[0] = SYSEX_START;
            body[1] = SYSEX_LEN;
            body[2] = SYSEX_ID_P;
            body[3] = SYSEX_ID_S;
            body[6] = req.sysex_difficulty;
            body[7] = req.sysex_kind;
            body[8] = {7'd0, req.sysex_on};
            body[9] = SYSEX_END;
            body_n  = 4'd10;
            last_note_on_in  = 1'b0;
            last_position_in = req.position[31:0];
         end
         OP_START_TRACK: begin
            body[0] = CHUNK_M;
            body[1] = CHUNK_T;
            body[2] = CHUNK_R;
            body[3] = CHUNK_K;
            body_n  = 4'd8;
            last_note_on_in  = 1'b0;
            last_channel_in  = 4'd0;
            last_position_in = 32'd0;
         end
         OP_END_TRACK: begin
            body[1] = META_EVENT;
            body[2] = META_END_TRACK;
            body_n  = 4'd4;
            last_note_on_in = 1'b0;
         end
         default: begin
            body_n = 4'd0;
         end
      endcase

      bi = 4'd0;
      for (int i = 0; i < MTE_MAX_BYTES; i++) begin
         bi = 4'(i) - {1'b0, delta_n};
         if (4'(i) < {1'b0, delta_n}) begin
            entry.bytes[i] = vlq[i % MTE_VLQ_BYTES];
         end else if (bi < 4'(MTE_BODY_BYTES)) begin
            entry.bytes[i] = body[bi];
         end else begin
            entry.bytes[i] = 8'h00;
         end
      end
      entry.count = body_n + {1'b0, delta_n};
      entry.error = 1'b0;
      if (fault) begin
         for (int i = 0; i < MTE_MAX_BYTES; i++) begin
            entry.bytes[i] = 8'h00;
         end
         entry.count      = 4'd1;
         entry.error      = 1'b1;
         last_position_in = last_position_ff;
         last_note_on_in  = last_note_on_ff;
         last_channel_in  = last_channel_ff;
      end
   end

   assign push = accept && op_known;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_position_ff <= 32'd0;
         last_note_on_ff  <= 1'b0;
         last_channel_ff  <= 4'd0;
      end else if (push) begin
         last_position_ff <= last_position_in;
         last_note_on_ff  <= last_note_on_in;
         last_channel_ff  <= last_channel_in;
      end
   end

endmodule

@@ hdl/mte_queue.sv @@
// Short queue of encoded events between the front and back ends.
// Depends on mte_pkg for the entry and status types.
module mte_queue #(
   parameter int DEPTH = mte_pkg::MTE_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mte_pkg::entry_type        push_entry,
   input  logic                      pop,
   output mte_pkg::entry_type        head,
   output mte_pkg::queue_status_type status
);
   import mte_pkg::*;

   localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);

   entry_type         slots_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign status.full  = (count_ff == CountW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/mte_back.sv @@
// Back end of the MIDI track event encoder (needs mte_pkg): sends the bytes
// of the queued event one per unstalled cycle via a registered output stage.
module mte_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mte_pkg::entry_type        head,
   input  mte_pkg::queue_status_type status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mte_pkg::byte_type         rsp_byte,
   output logic                      rsp_last,
   output logic                      rsp_error
);
   import mte_pkg::*;

   count_type idx_ff, idx_in;
   logic      valid_ff, valid_in;
   byte_type  byte_ff;
   logic      last_ff;
   logic      error_ff;
   logic      advance;
   logic      load;
   logic      at_end;

   assign advance = !valid_ff || rsp_ready;
   assign load    = advance && !status.empty;
   assign at_end  = (idx_ff == head.count - 4'd1);
   assign pop     = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = at_end ? 4'd0 : idx_ff + 4'd1;
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= head.bytes[idx_ff];
         last_ff  <= at_end;
         error_ff <= head.error;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_last  = last_ff;
   assign rsp_error = error_ff;

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && error_ff) |-> (last_ff && (byte_ff == 8'h00)))
      else $error("error item is not a single zero byte");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      !status.empty |-> (idx_ff < head.count))
      else $error("byte index beyond event length");

   a_error_first: assert property (@(posedge clock) disable iff (reset)
      (!status.empty && (idx_ff != 4'd0)) |-> !head.error)
      else $error("error event has more than one byte");

endmodule
